>>> hdl/blif_pkg.sv
// shared constants, codes and a helper function for the bulletin length indicator framer
package blif_pkg;

	localparam int DEF_MAX_NNN_DIGITS = 5;
	localparam int DEC_W = 30;        // wide enough for 10^9 - 1
	localparam int PIDX_W = 4;
	localparam int WMO_DIGITS = 8;
	localparam logic [31:0] WMO_MAX = 32'd99999999;

	localparam logic [2:0] FMT_ASCII      = 3'd0;
	localparam logic [2:0] FMT_TWO        = 3'd1;
	localparam logic [2:0] FMT_LBF        = 3'd2;
	localparam logic [2:0] FMT_HBF        = 3'd3;
	localparam logic [2:0] FMT_MSS        = 3'd4;
	localparam logic [2:0] FMT_WMO        = 3'd5;
	localparam logic [2:0] FMT_WMO_DUMMY  = 3'd6;
	localparam logic [2:0] FMT_ZERO_WORDS = 3'd7;

	localparam logic [1:0] CMD_BEGIN  = 2'd0;
	localparam logic [1:0] CMD_DATA   = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_NNN    = 2'd1;

	localparam logic [7:0] CH_SOH  = 8'd1;
	localparam logic [7:0] CH_CR   = 8'd13;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] MSS_LEAD = 8'd250;

	function automatic logic [DEC_W-1:0] pow10(input logic [PIDX_W-1:0] k);
		logic [DEC_W-1:0] p;
		case (k)
			4'd0: p = DEC_W'(1);
			4'd1: p = DEC_W'(10);
			4'd2: p = DEC_W'(100);
			4'd3: p = DEC_W'(1000);
			4'd4: p = DEC_W'(10000);
			4'd5: p = DEC_W'(100000);
			4'd6: p = DEC_W'(1000000);
			4'd7: p = DEC_W'(10000000);
			4'd8: p = DEC_W'(100000000);
			4'd9: p = DEC_W'(1000000000);
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

>>> hdl/bulletin_length_indicator_framer.sv
// top level: bulletin length indicator framer, one byte out per cycle while out_stall is low
//
// usage
// - input channel (in_valid / in_stall) takes begin, data and finish items;
//   an item is a transfer when in_valid is high and in_stall is low
// - output channel (out_valid / out_stall) gives the assembled byte stream,
//   out_last marks the final byte caused by one input item
// - config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   format (index 0) and nnn digit count (index 1); cfg_ready is always high
// the first byte of an item is registered in the job mask and then in the output register
// throughput: one output byte per cycle while out_stall is low; an item
//   of at most one byte (plain data) lets the next item in as it is emitted,
//   an item of n bytes holds the input until its last byte, set by the single
//   byte-wide output register (header bursts are at most 19 bytes at five nnn digits)
// decimal digits come from a one-digit-per-cycle compare/subtract unit while out_stall is low
// reset clears the job, the output valid flag and all framing state; config
//   returns to ascii format with no nnn counter
// a stalled receiver freezes the output register and the job; the input
//   is stalled until the job is on its last byte
module bulletin_length_indicator_framer #(
	parameter int MAX_NNN_DIGITS = blif_pkg::DEF_MAX_NNN_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [30:0] bulletin_length,
	input  logic        framed,
	input  logic [7:0]  data_byte,
	input  logic        data_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);
	import blif_pkg::*;

	localparam int SEQ_W = $clog2(10 ** MAX_NNN_DIGITS);
	// byte slot schedule of one job
	localparam int S_Z0   = 0;
	localparam int S_B0   = 4;
	localparam int S_W0   = 8;
	localparam int S_WT0  = 16;
	localparam int S_WT1  = 17;
	localparam int S_SOH  = 18;
	localparam int S_CR0  = 19;
	localparam int S_CR1  = 20;
	localparam int S_LF   = 21;
	localparam int S_N0   = 22;
	localparam int S_D    = S_N0 + MAX_NNN_DIGITS;
	localparam int S_T0   = S_D + 1;
	localparam int NSLOT  = S_T0 + 4;
	localparam int SLOT_W = $clog2(NSLOT);

	// configuration
	logic [2:0] fmt_q;
	logic [2:0] nnn_q;

	// framing state
	logic             file_started_q;
	logic             last_framed_q;
	logic             skip_q;
	logic [SEQ_W-1:0] seq_q;
	logic [30:0]      held_q;

	// job registers
	logic [NSLOT-1:0]  mask_q;
	logic [31:0]       hdr_q;
	logic [31:0]       trl_q;
	logic [7:0]        data_q;
	logic              fr_q;
	logic [DEC_W-1:0]  dec_q;
	logic [PIDX_W-1:0] pidx_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic [PIDX_W-1:0] digits;
	logic              accept;
	logic              emit;
	logic              job_last;
	logic [SLOT_W-1:0] cur;
	logic [NSLOT-1:0]  new_mask;
	logic [31:0]       total;
	logic [DEC_W-1:0]  wmo_val;
	logic [SEQ_W-1:0]  seq_next;
	logic [DEC_W-1:0]  seq_max;
	logic [DEC_W-1:0]  pw;
	logic [DEC_W-1:0]  sub;
	logic [3:0]        digit;
	logic [7:0]        slot_byte;
	logic              is_digit_slot;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// digit count, clipped to the supported maximum
	assign digits = (PIDX_W'(nnn_q) > PIDX_W'(MAX_NNN_DIGITS)) ?
		PIDX_W'(MAX_NNN_DIGITS) : PIDX_W'(nnn_q);

	assign emit     = (mask_q != '0) && (!out_valid_q || !out_stall);
	assign job_last = $onehot(mask_q);
	assign in_stall = !((mask_q == '0) || (emit && job_last));
	assign accept   = in_valid && !in_stall;

	// lowest pending slot
	always_comb begin
		cur = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				cur = SLOT_W'(i);
			end
		end
	end

	// header length and sequence counter advance
	always_comb begin
		total = {1'b0, bulletin_length} +
			((digits != '0) ? 32'(digits) + 32'd3 : 32'd0);
		wmo_val = (total > WMO_MAX) ? DEC_W'(WMO_MAX) : DEC_W'(total);
		seq_max = pow10(digits) - DEC_W'(1);
		seq_next = seq_q + SEQ_W'(1);
		if (DEC_W'(seq_next) > seq_max || seq_next == '0) begin
			seq_next = '0;
		end
	end

	// which slots the incoming item fills
	always_comb begin
		new_mask = '0;
		unique case (cmd)
			CMD_BEGIN: begin
				if (bulletin_length != '0) begin
					if (!file_started_q && fmt_q == FMT_ZERO_WORDS) begin
						new_mask[S_Z0 +: 4] = 4'hf;
					end
					case (fmt_q)
						FMT_TWO: new_mask[S_B0 +: 2] = 2'h3;
						FMT_LBF, FMT_HBF, FMT_MSS, FMT_ZERO_WORDS:
							new_mask[S_B0 +: 4] = 4'hf;
						FMT_WMO, FMT_WMO_DUMMY:
							new_mask[S_W0 +: 10] = 10'h3ff;
						default: ;
					endcase
					if (digits != '0) begin
						new_mask[S_SOH] = framed;
						new_mask[S_CR0] = 1'b1;
						new_mask[S_CR1] = 1'b1;
						new_mask[S_LF]  = 1'b1;
						for (int i = 0; i < MAX_NNN_DIGITS; i++) begin
							if (PIDX_W'(i) < digits) begin
								new_mask[S_N0 + i] = 1'b1;
							end
						end
					end
				end
			end
			CMD_DATA: begin
				new_mask[S_D] = !skip_q;
				if (data_last && fmt_q == FMT_ZERO_WORDS) begin
					new_mask[S_T0 +: 4] = 4'hf;
				end
			end
			CMD_FINISH: begin
				if (file_started_q) begin
					if (fmt_q == FMT_ZERO_WORDS) begin
						new_mask[S_T0 +: 4] = 4'hf;
					end else if (fmt_q == FMT_WMO_DUMMY) begin
						new_mask[S_W0 +: 10] = 10'h3ff;
					end
				end
			end
			default: ;
		endcase
	end

	// one decimal digit per step, most significant first
	always_comb begin
		pw = pow10(pidx_q);
		digit = '0;
		sub = '0;
		for (int d = 1; d < 10; d++) begin
			if (dec_q >= DEC_W'(d) * pw) begin
				digit = 4'(d);
				sub = DEC_W'(d) * pw;
			end
		end
	end

	// byte of the current slot
	always_comb begin
		is_digit_slot = 1'b0;
		slot_byte = '0;
		if (int'(cur) < S_B0) begin
			slot_byte = '0;
		end else if (int'(cur) < S_W0) begin
			case (fmt_q)
				FMT_TWO, FMT_LBF:
					slot_byte = hdr_q[8 * (int'(cur) - S_B0) +: 8];
				FMT_MSS:
					slot_byte = (int'(cur) == S_B0) ? MSS_LEAD :
						hdr_q[8 * (S_B0 + 3 - int'(cur)) +: 8];
				default:
					slot_byte = hdr_q[8 * (S_B0 + 3 - int'(cur)) +: 8];
			endcase
		end else if (int'(cur) < S_WT0) begin
			is_digit_slot = 1'b1;
			slot_byte = CH_ZERO + 8'(digit);
		end else if (int'(cur) == S_WT0) begin
			slot_byte = CH_ZERO;
		end else if (int'(cur) == S_WT1) begin
			slot_byte = fr_q ? CH_ZERO : CH_ONE;
		end else if (int'(cur) == S_SOH) begin
			slot_byte = CH_SOH;
		end else if (int'(cur) == S_CR0 || int'(cur) == S_CR1) begin
			slot_byte = CH_CR;
		end else if (int'(cur) == S_LF) begin
			slot_byte = CH_LF;
		end else if (int'(cur) < S_D) begin
			is_digit_slot = 1'b1;
			slot_byte = CH_ZERO + 8'(digit);
		end else if (int'(cur) == S_D) begin
			slot_byte = data_q;
		end else begin
			slot_byte = trl_q[8 * (S_T0 + 3 - int'(cur)) +: 8];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_ASCII;
			nnn_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_FORMAT) begin
				fmt_q <= cfg_data;
			end else if (cfg_index == REG_NNN) begin
				nnn_q <= cfg_data;
			end
		end
	end

	// framing state, updated at each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_started_q <= 1'b0;
			last_framed_q  <= 1'b1;
			skip_q         <= 1'b0;
			seq_q          <= '0;
			held_q         <= '0;
		end else if (accept) begin
			case (cmd)
				CMD_BEGIN: begin
					if (bulletin_length != '0) begin
						file_started_q <= 1'b1;
						last_framed_q  <= framed;
						skip_q         <= framed && (digits != '0);
						held_q         <= bulletin_length;
						if (digits != '0) begin
							seq_q <= seq_next;
						end
					end
				end
				CMD_DATA: skip_q <= 1'b0;
				CMD_FINISH: begin
					file_started_q <= 1'b0;
					last_framed_q  <= 1'b1;
					skip_q         <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// job mask and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mask_q <= new_mask;
			end else if (emit) begin
				mask_q[cur] <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// job payload, byte payload and the digit unit
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= slot_byte;
			out_last_q <= job_last;
		end
		if (accept) begin
			hdr_q  <= total;
			data_q <= data_byte;
			fr_q   <= (cmd == CMD_BEGIN) ? framed : last_framed_q;
			trl_q  <= (cmd == CMD_DATA) ? {1'b0, held_q} : 32'd0;
			dec_q  <= (cmd == CMD_BEGIN) ? wmo_val : '0;
			pidx_q <= PIDX_W'(WMO_DIGITS - 1);
		end else if (emit) begin
			if (is_digit_slot) begin
				dec_q  <= dec_q - sub;
				pidx_q <= pidx_q - PIDX_W'(1);
			end else if (int'(cur) == S_CR0) begin
				dec_q  <= DEC_W'(seq_q);
				pidx_q <= digits - PIDX_W'(1);
			end
		end
	end

	// input is taken only when the job is empty or on its final byte
	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (mask_q == '0 || (emit && job_last)))
		else $error("input taken while job still pending");

	// a stalled output register is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("output register overwritten under stall");

	// digit unit stays within one decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && is_digit_slot) |-> (dec_q < pow10(pidx_q + PIDX_W'(1))))
		else $error("decimal digit out of range");

	// the job is empty after its final byte unless a new item is taken
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && job_last && !accept) |=> (mask_q == '0))
		else $error("job not empty after last byte");

endmodule
